@@ rtl/cmf_pkg.sv @@
// ============================================================================
// cmf_pkg - shared types and helpers for the cross median filter
// Pixel and counter widths, register codes, the front-to-back job record
// and the five-input median used by the back end.
// ============================================================================
package cmf_pkg;

	localparam int PIX_W      = 8;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W    = 9;
	localparam int HEIGHT_W   = 13;
	localparam int RAM_W      = 2 * PIX_W;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// register index codes (paddr[2])
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(160);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(160);

	localparam logic [PIX_W-1:0] PIX_MIN = '0;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	// job queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// frame geometry and restart request from the register block
	typedef struct packed {
		logic             restart;
		logic [COL_W-1:0] last_col;
		logic [ROW_W-1:0] last_row;
	} cfg_t;

	// one accepted pixel with everything its results need
	typedef struct packed {
		logic [PIX_W-1:0] x;      // current input
		logic [PIX_W-1:0] up;     // row above, this column
		logic [PIX_W-1:0] up2;    // two rows above, this column
		logic [PIX_W-1:0] right;  // row above, next column
		logic [PIX_W-1:0] h0;     // previous input
		logic [PIX_W-1:0] h1;     // input before that
		logic [PIX_W-1:0] h2;     // row above, previous column
		logic             has_up2;
		logic             has_left;
		logic             has_left2;
		logic             has_right;
		logic             do_col;   // result for the pixel above
		logic             do_left;  // last row: result for the left pixel
		logic             do_last;  // last row: result for the frame's final pixel
	} job_t;

	// median of five: pairwise sort, drop the smaller minimum twice
	function automatic logic [PIX_W-1:0] median5(
		input logic [PIX_W-1:0] a_in,
		input logic [PIX_W-1:0] b_in,
		input logic [PIX_W-1:0] c_in,
		input logic [PIX_W-1:0] d_in,
		input logic [PIX_W-1:0] e_in
	);
		logic [PIX_W-1:0] a, b, c, d, p, q, t;
		a = a_in;
		b = b_in;
		c = c_in;
		d = d_in;
		if (a > b) begin
			t = a; a = b; b = t;
		end
		if (c > d) begin
			t = c; c = d; d = t;
		end
		// a is now the minimum of the first four when a <= c
		if (a > c) begin
			t = a; a = c; c = t;
			t = b; b = d; d = t;
		end
		p = (b < e_in) ? b : e_in;
		q = (b < e_in) ? e_in : b;
		if (p > c) begin
			t = p; p = c; c = t;
			t = q; q = d; d = t;
		end
		return (q < c) ? q : c;
	endfunction

endpackage

@@ rtl/cross_median_filter_core.sv @@
// ============================================================================
// cross_median_filter_core - plus-shaped 5-point median over a raster plane
// Pixels go in through push/full, medians come out through empty/pop, with
// an APB-style register port for frame width and height.
// ============================================================================
// Usage:
//  - Input queue side: drive pixel_in and push; a request is taken at a clock
//    edge with push high and full low; one pixel per cycle while full is low.
//  - Result queue side: while empty is low the oldest result is on
//    filtered_value, end_of_line, end_of_frame and last_in_run; pop takes it.
//  - Each pixel's median is produced when the pixel below it arrives, so
//    results trail the input by one row; on the last row a pixel can release
//    up to three results, drained at one per cycle while the receiver pops.
//  - A result passes through the job queue and then the output register
//    after the request that completes it; the line RAM read is registered
//    ahead of that request.
//  - Throughput: one request per cycle while full is low, one result per
//    cycle while popped; the single-result output register and four-entry
//    job queue set the rate, so last-row bursts fill the queue and raise full.
//  - A stalled receiver backs up the output register, then the job queue,
//    then full; nothing is dropped.
//  - Reset clears position, holds and queues; the line RAM needs no clear.
//    Width 0x0 and height 0x4 both reset to 160; any register write
//    restarts the frame at its first pixel.
// ============================================================================
module cross_median_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cmf_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [cmf_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [cmf_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready,
	// pixel input
	input  logic                                push,
	output logic                                full,
	input  logic [cmf_pkg::PIX_W-1:0]           pixel_in,
	// results
	output logic                                empty,
	input  logic                                pop,
	output logic [cmf_pkg::PIX_W-1:0]           filtered_value,
	output logic                                end_of_line,
	output logic                                end_of_frame,
	output logic                                last_in_run
);

	logic [cmf_pkg::WIDTH_W-1:0]  width_q;
	logic [cmf_pkg::HEIGHT_W-1:0] height_q;
	logic                         cfg_wr;
	logic                         reg_sel;
	cmf_pkg::cfg_t                cfg;
	cmf_pkg::job_t                q_in, q_out;
	logic                         q_push, q_full, q_pop, q_empty;

	// register block
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cmf_pkg::WIDTH_RESET;
			height_q <= cmf_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				cmf_pkg::REG_FRAME_WIDTH:  width_q  <= pwdata[cmf_pkg::WIDTH_W-1:0];
				cmf_pkg::REG_FRAME_HEIGHT: height_q <= pwdata[cmf_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			cmf_pkg::REG_FRAME_WIDTH:
				prdata = cmf_pkg::CFG_DATA_W'(width_q);
			cmf_pkg::REG_FRAME_HEIGHT:
				prdata = cmf_pkg::CFG_DATA_W'(height_q);
			default:
				prdata = '0;
		endcase
	end

	// saturated geometry as last column / last row indexes
	always_comb begin
		cfg.restart = cfg_wr;
		if (width_q < cmf_pkg::WIDTH_W'(2)) begin
			cfg.last_col = cmf_pkg::COL_W'(1);
		end else if (width_q > cmf_pkg::WIDTH_W'(cmf_pkg::MAX_WIDTH)) begin
			cfg.last_col = cmf_pkg::COL_W'(cmf_pkg::MAX_WIDTH - 1);
		end else begin
			cfg.last_col = cmf_pkg::COL_W'(width_q - 1'b1);
		end
		if (height_q < cmf_pkg::HEIGHT_W'(2)) begin
			cfg.last_row = cmf_pkg::ROW_W'(1);
		end else if (height_q > cmf_pkg::HEIGHT_W'(cmf_pkg::MAX_HEIGHT)) begin
			cfg.last_row = cmf_pkg::ROW_W'(cmf_pkg::MAX_HEIGHT - 1);
		end else begin
			cfg.last_row = cmf_pkg::ROW_W'(height_q - 1'b1);
		end
	end

	cmf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.push     (push),
		.pixel_in (pixel_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	assign full = q_full;

	cmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	cmf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job            (q_out),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.filtered_value (filtered_value),
		.end_of_line    (end_of_line),
		.end_of_frame   (end_of_frame),
		.last_in_run    (last_in_run)
	);

endmodule

@@ rtl/cmf_ram.sv @@
// ============================================================================
// cmf_ram - generic RAM, one write port, two registered read ports
// Read returns the old contents when read and write hit the same address.
// ============================================================================
module cmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// storage and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/cmf_front.sv @@
// ============================================================================
// cmf_front - pixel intake and classification
// Tracks the raster position, keeps the two line stores and left holds,
// and turns each accepted pixel into a job record for the back end.
// ============================================================================
module cmf_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmf_pkg::cfg_t              cfg,
	input  logic                       push,
	input  logic [cmf_pkg::PIX_W-1:0]  pixel_in,
	input  logic                       q_full,
	output logic                       q_push,
	output cmf_pkg::job_t              q_data
);

	logic [cmf_pkg::COL_W-1:0] col_q, col_nx, addr_a, addr_b;
	logic [cmf_pkg::ROW_W-1:0] row_q, row_nx;
	logic [cmf_pkg::PIX_W-1:0] h0_q, h1_q, h2_q, fwd_q;
	logic                      hit_q;
	logic [cmf_pkg::RAM_W-1:0] rd_a, rd_b, wdata;
	logic                      accept, last_col, last_row;
	logic [cmf_pkg::PIX_W-1:0] up, up2, right;
	cmf_pkg::job_t             job;

	assign accept   = push && !q_full;
	assign last_col = (col_q == cfg.last_col);
	assign last_row = (row_q == cfg.last_row);

	// next raster position
	always_comb begin
		if (last_col) begin
			col_nx = '0;
			row_nx = last_row ? '0 : row_q + 1'b1;
		end else begin
			col_nx = col_q + 1'b1;
			row_nx = row_q;
		end
	end

	// read ahead at the column of the next request
	always_comb begin
		if (cfg.restart) begin
			addr_a = '0;
		end else if (accept) begin
			addr_a = col_nx;
		end else begin
			addr_a = col_q;
		end
	end
	assign addr_b = addr_a + 1'b1;

	// entry layout: [PIX_W-1:0] row above, [RAM_W-1:PIX_W] two rows above
	assign up    = rd_a[cmf_pkg::PIX_W-1:0];
	assign up2   = rd_a[cmf_pkg::RAM_W-1:cmf_pkg::PIX_W];
	assign right = hit_q ? fwd_q : rd_b[cmf_pkg::PIX_W-1:0];
	assign wdata = {up, pixel_in};

	cmf_ram #(
		.WIDTH (cmf_pkg::RAM_W),
		.DEPTH (cmf_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.we      (accept),
		.waddr   (col_q),
		.wdata   (wdata),
		.raddr_a (addr_a),
		.rdata_a (rd_a),
		.raddr_b (addr_b),
		.rdata_b (rd_b)
	);

	// write-to-read forwarding on port b (two-column frames wrap onto it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= accept && (addr_b == col_q);
		end
	end

	always_ff @(posedge clk) begin
		fwd_q <= pixel_in;
	end

	// position counters and left holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			h0_q  <= '0;
			h1_q  <= '0;
			h2_q  <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
			h0_q  <= '0;
			h1_q  <= '0;
			h2_q  <= '0;
		end else if (accept) begin
			col_q <= col_nx;
			row_q <= row_nx;
			h1_q  <= h0_q;
			h0_q  <= pixel_in;
			h2_q  <= up;
		end
	end

	// job record
	always_comb begin
		job.x         = pixel_in;
		job.up        = up;
		job.up2       = up2;
		job.right     = right;
		job.h0        = h0_q;
		job.h1        = h1_q;
		job.h2        = h2_q;
		job.has_up2   = (row_q > cmf_pkg::ROW_W'(1));
		job.has_left  = (col_q != '0);
		job.has_left2 = (col_q > cmf_pkg::COL_W'(1));
		job.has_right = !last_col;
		job.do_col    = (row_q != '0);
		job.do_left   = last_row && (col_q != '0);
		job.do_last   = last_row && last_col;
	end

	// pixels of the first row give no result and are not queued
	assign q_push = accept && (job.do_col || job.do_left || job.do_last);
	assign q_data = job;

endmodule

@@ rtl/cmf_queue.sv @@
// ============================================================================
// cmf_queue - short job queue between front and back
// Register-based FIFO; the head entry is always on pop_data.
// ============================================================================
module cmf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmf_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output cmf_pkg::job_t pop_data,
	output logic          empty
);

	cmf_pkg::job_t                 entry_q [cmf_pkg::Q_DEPTH];
	logic [cmf_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [cmf_pkg::Q_CNT_W-1:0]   cnt_q;
	logic                          do_push, do_pop;

	assign full     = (cnt_q == cmf_pkg::Q_CNT_W'(cmf_pkg::Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/cmf_back.sv @@
// ============================================================================
// cmf_back - median evaluation and result output
// Works through the one to three results of the head job, one per cycle while
// the receiver keeps up, into an output register that the receiver pops.
// ============================================================================
module cmf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmf_pkg::job_t             job,
	input  logic                      q_empty,
	output logic                      q_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic [cmf_pkg::PIX_W-1:0] filtered_value,
	output logic                      end_of_line,
	output logic                      end_of_frame,
	output logic                      last_in_run
);

	logic [2:0]                done_q, pend, sel, rest;
	logic                      out_valid_q, value_eol_q, value_eof_q, lir_q;
	logic [cmf_pkg::PIX_W-1:0] value_q;
	logic                      load, advance, fill;
	logic [cmf_pkg::PIX_W-1:0] v0, v1, v2, v3, v4, med;
	logic                      eol, eof;

	// results still owed by the head job, oldest first
	assign pend = {job.do_last, job.do_left, job.do_col} & ~done_q;
	always_comb begin
		if (pend[0]) begin
			sel = 3'b001;
		end else if (pend[1]) begin
			sel = 3'b010;
		end else begin
			sel = 3'b100;
		end
	end
	assign rest = pend & ~sel;

	// operand select; absent neighbors padded with low/high so that
	// five-way median gives the lower middle of four or the middle of three
	always_comb begin
		case (sel)
			3'b001: begin
				v0 = job.up;
				v1 = job.x;
				v2 = job.has_up2 ? job.up2 : cmf_pkg::PIX_MIN;
				v3 = job.has_left ? job.h2
				   : (job.has_up2 ? cmf_pkg::PIX_MIN : cmf_pkg::PIX_MAX);
				v4 = job.has_right ? job.right
				   : (job.has_up2 ? cmf_pkg::PIX_MIN : cmf_pkg::PIX_MAX);
				eol = !job.has_right;
				eof = 1'b0;
			end
			3'b010: begin
				v0 = job.h0;
				v1 = job.h2;
				v2 = job.x;
				v3 = job.has_left2 ? job.h1 : cmf_pkg::PIX_MIN;
				v4 = job.has_left2 ? cmf_pkg::PIX_MIN : cmf_pkg::PIX_MAX;
				eol = 1'b0;
				eof = 1'b0;
			end
			default: begin
				v0 = job.x;
				v1 = job.up;
				v2 = job.h0;
				v3 = cmf_pkg::PIX_MIN;
				v4 = cmf_pkg::PIX_MAX;
				eol = 1'b1;
				eof = 1'b1;
			end
		endcase
	end

	assign med = cmf_pkg::median5(v0, v1, v2, v3, v4);

	// output register takes a new result when empty or being popped
	assign load    = !out_valid_q || pop;
	assign advance = load && !q_empty;
	assign fill    = advance && (pend != '0);
	assign q_pop   = advance && (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= fill;
			end
			if (q_pop) begin
				done_q <= '0;
			end else if (advance) begin
				done_q <= done_q | sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill) begin
			value_q     <= med;
			value_eol_q <= eol;
			value_eof_q <= eof;
			lir_q       <= (rest == '0);
		end
	end

	assign empty          = !out_valid_q;
	assign filtered_value = value_q;
	assign end_of_line    = value_eol_q;
	assign end_of_frame   = value_eof_q;
	assign last_in_run    = lir_q;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the cross median filter core
// Streams pixel frames through the push/full side, programs frame width and
// height over the register port, and checks every popped median and its
// line, frame and run flags against an in-bench line-buffer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import cmf_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 60;
	localparam int RANDOM_ITEMS = 250;
	localparam int END_LIMIT    = 20000;
	localparam int MAX_REPORTS  = 40;
	localparam int LIMIT_CYCLES = 400000;

	// one popped result
	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             line_end;
		logic             frame_end;
		logic             run_end;
	} median_out_t;

	typedef enum logic [1:0] {DO_WRITE, DO_READ, DO_PIXEL} stim_kind_e;
	typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_EVERY_THIRD} rx_mode_e;

	// directed stimulus row; word is write data or expected read data
	typedef struct packed {
		stim_kind_e       kind;
		logic             reg_sel;
		logic [31:0]      word;
		logic [PIX_W-1:0] pixel;
		logic             pinned;
		logic [PIX_W-1:0] pinned_value;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  push;
	logic                  full;
	logic [PIX_W-1:0]      pixel_in;
	logic                  empty;
	logic                  pop;
	logic [PIX_W-1:0]      filtered_value;
	logic                  end_of_line;
	logic                  end_of_frame;
	logic                  last_in_run;

	cross_median_filter_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.push           (push),
		.full           (full),
		.pixel_in       (pixel_in),
		.empty          (empty),
		.pop            (pop),
		.filtered_value (filtered_value),
		.end_of_line    (end_of_line),
		.end_of_frame   (end_of_frame),
		.last_in_run    (last_in_run)
	);

	// predictor state
	logic [WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
	logic [PIX_W-1:0]    line_above     [MAX_WIDTH] = '{default: '0};
	logic [PIX_W-1:0]    line_two_above [MAX_WIDTH] = '{default: '0};
	logic [COL_W-1:0]    col_pos     = '0;
	logic [ROW_W-1:0]    row_pos     = '0;
	logic [PIX_W-1:0]    prev_pixel  = '0;
	logic [PIX_W-1:0]    prev_pixel2 = '0;
	logic [PIX_W-1:0]    up_left     = '0;

	median_out_t pending_medians[$];

	// values pinned by the directed table for the item on the bus
	logic             drv_pinned;
	logic [PIX_W-1:0] drv_pinned_value;

	int unsigned mismatch_count;
	int unsigned pixels_taken;
	int unsigned results_seen;
	int unsigned frames_seen;
	int unsigned reg_writes;

	stim_row_t directed_rows [0:36];

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	function automatic int clamp_cols(input logic [WIDTH_W-1:0] raw);
		if (raw < 2) return 2;
		if (raw > MAX_WIDTH) return MAX_WIDTH;
		return int'(raw);
	endfunction

	function automatic int clamp_rows(input logic [HEIGHT_W-1:0] raw);
		if (raw < 2) return 2;
		if (raw > MAX_HEIGHT) return MAX_HEIGHT;
		return int'(raw);
	endfunction

	// insertion sort, then the lower middle
	function automatic logic [PIX_W-1:0] median_of(input logic [PIX_W-1:0] vals [0:4],
			input int n);
		logic [PIX_W-1:0] s [0:4];
		logic [PIX_W-1:0] key;
		int               i;
		int               j;
		s = vals;
		for (i = 1; i < n; i++) begin
			key = s[i];
			j = i - 1;
			while (j >= 0 && s[j] > key) begin
				s[j + 1] = s[j];
				j--;
			end
			s[j + 1] = key;
		end
		return s[(n - 1) / 2];
	endfunction

	function automatic void queue_median(input logic [PIX_W-1:0] value, input logic eol,
			input logic eof);
		median_out_t m;
		m.value     = value;
		m.line_end  = eol;
		m.frame_end = eof;
		m.run_end   = 1'b0;
		pending_medians.push_back(m);
	endfunction

	// any register write restarts the frame
	function automatic void apply_reg_write(input logic sel, input logic [31:0] word);
		if (sel == REG_FRAME_WIDTH)
			width_reg = word[WIDTH_W-1:0];
		else
			height_reg = word[HEIGHT_W-1:0];
		col_pos     = '0;
		row_pos     = '0;
		prev_pixel  = '0;
		prev_pixel2 = '0;
		up_left     = '0;
	endfunction

	// expected medians released by one accepted pixel
	function automatic void predict_pixel(input logic [PIX_W-1:0] x, input logic pinned,
			input logic [PIX_W-1:0] pinned_value);
		logic [PIX_W-1:0] v [0:4];
		int               w;
		int               h;
		int               c;
		int               r;
		int               n;
		int               first;
		int               i;
		w = clamp_cols(width_reg);
		h = clamp_rows(height_reg);
		c = int'(col_pos);
		r = int'(row_pos);
		if (c >= w) c = w - 1;
		if (r >= h) r = h - 1;
		first = pending_medians.size();
		v = '{default: '0};

		// pixel above is now complete
		if (r > 0) begin
			v[0] = line_above[c];
			v[1] = x;
			n = 2;
			if (r >= 2) begin
				v[n] = line_two_above[c];
				n++;
			end
			if (c > 0) begin
				v[n] = up_left;
				n++;
			end
			if (c + 1 < w) begin
				v[n] = line_above[c + 1];
				n++;
			end
			queue_median(median_of(v, n), c + 1 == w, 1'b0);
		end

		// last row: flush the left pixel and the frame's final pixel
		if (r == h - 1) begin
			if (c > 0) begin
				v[0] = prev_pixel;
				v[1] = up_left;
				v[2] = x;
				n = 3;
				if (c >= 2) begin
					v[3] = prev_pixel2;
					n = 4;
				end
				queue_median(median_of(v, n), 1'b0, 1'b0);
			end
			if (c + 1 == w) begin
				v[0] = x;
				v[1] = line_above[c];
				v[2] = prev_pixel;
				queue_median(median_of(v, 3), 1'b1, 1'b1);
			end
		end

		if (pending_medians.size() > first)
			pending_medians[pending_medians.size() - 1].run_end = 1'b1;
		if (pinned) begin
			for (i = first; i < pending_medians.size(); i++)
				pending_medians[i].value = pinned_value;
		end

		prev_pixel2       = prev_pixel;
		prev_pixel        = x;
		up_left           = line_above[c];
		line_two_above[c] = line_above[c];
		line_above[c]     = x;
		if (c + 1 >= w) begin
			col_pos = '0;
			row_pos = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
		end else begin
			col_pos = COL_W'(c + 1);
			row_pos = ROW_W'(r);
		end
	endfunction

	// monitor: register writes, accepted pixels, popped results
	median_out_t got_median;
	median_out_t want_median;

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				apply_reg_write(paddr[2], pwdata);
				reg_writes++;
			end
			if (push && !full) begin
				predict_pixel(pixel_in, drv_pinned, drv_pinned_value);
				pixels_taken++;
			end
			if (pop && !empty) begin
				got_median = '{filtered_value, end_of_line, end_of_frame, last_in_run};
				results_seen++;
				if (end_of_frame)
					frames_seen++;
				if (pending_medians.size() == 0) begin
					report_mismatch("result with none expected", got_median.value, 0);
				end else begin
					want_median = pending_medians.pop_front();
					if (got_median.value !== want_median.value)
						report_mismatch("filtered_value", got_median.value, want_median.value);
					if (got_median.line_end !== want_median.line_end)
						report_mismatch("end_of_line", got_median.line_end,
							want_median.line_end);
					if (got_median.frame_end !== want_median.frame_end)
						report_mismatch("end_of_frame", got_median.frame_end,
							want_median.frame_end);
					if (got_median.run_end !== want_median.run_end)
						report_mismatch("last_in_run", got_median.run_end,
							want_median.run_end);
				end
			end
		end
	end

	// receiver: changing stall patterns plus occasional long hold-offs
	initial begin : result_drain
		rx_mode_e    mode;
		int          mode_left;
		int unsigned tick;
		int unsigned next_hold_at;
		mode         = RX_ALWAYS;
		mode_left    = 40;
		tick         = 0;
		next_hold_at = 30;
		pop          = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (results_seen >= next_hold_at) begin
				// long hold-off so the block backs up and raises full
				next_hold_at = results_seen + 150;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					RX_ALWAYS:      pop <= 1'b1;
					RX_HALF:        pop <= 1'($urandom_range(0, 1));
					RX_SPARSE:      pop <= ($urandom_range(0, 3) == 0);
					RX_EVERY_THIRD: pop <= (tick % 3 == 0);
					default:        pop <= 1'b1;
				endcase
			end
		end
	end

	// offer one pixel and hold it until taken
	task automatic send_pixel(input logic [PIX_W-1:0] value, input logic pinned,
			input logic [PIX_W-1:0] pinned_value);
		@(negedge clk);
		push             <= 1'b1;
		pixel_in         <= value;
		drv_pinned       <= pinned;
		drv_pinned_value <= pinned_value;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic idle_gap(input int cycles);
		@(negedge clk);
		push <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// stop sending and let every expected result drain
	task automatic wait_for_idle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [31:0] word);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_reg(input logic sel, input logic [31:0] want);
		@(negedge clk);
		push    <= 1'b0;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {sel, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== want)
			report_mismatch(sel == REG_FRAME_WIDTH ? "frame_width readback" :
				"frame_height readback", prdata, want);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// stimulus
	initial begin : stimulus
		int            phase;
		int            random_sent;
		int            w;
		int            h;
		int            n;
		int            i;
		int            burst_left;
		bit            no_gaps;
		bit            tall;
		logic [31:0]   width_word;
		logic [31:0]   height_word;
		int            waited;

		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		push             = 1'b0;
		pixel_in         = '0;
		drv_pinned       = 1'b0;
		drv_pinned_value = '0;
		mismatch_count   = 0;
		pixels_taken     = 0;
		results_seen     = 0;
		frames_seen      = 0;
		reg_writes       = 0;

		directed_rows = '{
			// reset values
			'{DO_READ,  REG_FRAME_WIDTH,  32'd160,  8'd0,   1'b0, 8'd0},
			'{DO_READ,  REG_FRAME_HEIGHT, 32'd160,  8'd0,   1'b0, 8'd0},
			// width 0 and height 1 saturate to a 2x2 frame
			'{DO_WRITE, REG_FRAME_WIDTH,  32'd0,    8'd0,   1'b0, 8'd0},
			'{DO_WRITE, REG_FRAME_HEIGHT, 32'd1,    8'd0,   1'b0, 8'd0},
			'{DO_READ,  REG_FRAME_WIDTH,  32'd0,    8'd0,   1'b0, 8'd0},
			// flat frames: every median equals the flat value
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd255, 1'b1, 8'd255},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd255, 1'b1, 8'd255},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd255, 1'b1, 8'd255},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd255, 1'b1, 8'd255},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd0,   1'b1, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd0,   1'b1, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd0,   1'b1, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd0,   1'b1, 8'd0},
			// 3x3: corners, edges and one full cross
			'{DO_WRITE, REG_FRAME_WIDTH,  32'd3,    8'd0,   1'b0, 8'd0},
			'{DO_WRITE, REG_FRAME_HEIGHT, 32'd3,    8'd0,   1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd10,  1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd200, 1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd30,  1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd250, 1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd0,   1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd90,  1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd60,  1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd128, 1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd255, 1'b0, 8'd0},
			// oversized values saturate to the largest frame; first row is silent
			'{DO_WRITE, REG_FRAME_WIDTH,  32'd511,  8'd0,   1'b0, 8'd0},
			'{DO_WRITE, REG_FRAME_HEIGHT, 32'd8191, 8'd0,   1'b0, 8'd0},
			'{DO_READ,  REG_FRAME_HEIGHT, 32'd8191, 8'd0,   1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd7,   1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd77,  1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd177, 1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd255, 1'b0, 8'd0},
			// restart in the middle of a frame
			'{DO_WRITE, REG_FRAME_WIDTH,  32'd2,    8'd0,   1'b0, 8'd0},
			'{DO_WRITE, REG_FRAME_HEIGHT, 32'd2,    8'd0,   1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd255, 1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd0,   1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd255, 1'b0, 8'd0},
			'{DO_PIXEL, REG_FRAME_WIDTH,  32'd0,    8'd0,   1'b0, 8'd0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[k]) begin
			case (directed_rows[k].kind)
				DO_WRITE: begin
					wait_for_idle();
					write_reg(directed_rows[k].reg_sel, directed_rows[k].word);
				end
				DO_READ:  read_reg(directed_rows[k].reg_sel, directed_rows[k].word);
				default:  send_pixel(directed_rows[k].pixel, directed_rows[k].pinned,
					directed_rows[k].pinned_value);
			endcase
		end

		// random frames, under a fixed 8x5 geometry first and random geometry after
		phase       = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			width_word  = $urandom;
			height_word = $urandom;
			if (phase == 0) begin
				width_word[WIDTH_W-1:0]   = WIDTH_W'(8);
				height_word[HEIGHT_W-1:0] = HEIGHT_W'(5);
			end else begin
				case ($urandom_range(0, 9))
					0:       width_word[WIDTH_W-1:0] = WIDTH_W'($urandom_range(0, 1));
					1:       width_word[WIDTH_W-1:0] = WIDTH_W'($urandom_range(11, 24));
					default: width_word[WIDTH_W-1:0] = WIDTH_W'($urandom_range(2, 10));
				endcase
				case ($urandom_range(0, 6))
					0:       height_word[HEIGHT_W-1:0] = HEIGHT_W'($urandom_range(0, 1));
					1:       height_word[HEIGHT_W-1:0] = HEIGHT_W'($urandom_range(4096, 8191));
					default: height_word[HEIGHT_W-1:0] = HEIGHT_W'($urandom_range(2, 5));
				endcase
			end
			w    = clamp_cols(width_word[WIDTH_W-1:0]);
			h    = clamp_rows(height_word[HEIGHT_W-1:0]);
			tall = (h == MAX_HEIGHT);

			wait_for_idle();
			if ($urandom_range(0, 1)) begin
				write_reg(REG_FRAME_WIDTH, width_word);
				write_reg(REG_FRAME_HEIGHT, height_word);
			end else begin
				write_reg(REG_FRAME_HEIGHT, height_word);
				write_reg(REG_FRAME_WIDTH, width_word);
			end
			if ($urandom_range(0, 3) == 0) begin
				read_reg(REG_FRAME_WIDTH, 32'(width_word[WIDTH_W-1:0]));
				read_reg(REG_FRAME_HEIGHT, 32'(height_word[HEIGHT_W-1:0]));
			end

			// whole frames, sometimes ending partway through one; tall frames send only two or three rows and part of the next
			if (phase == 0)
				n = 2 * w * h;
			else if (tall)
				n = w * $urandom_range(2, 3) + $urandom_range(0, w - 1);
			else
				n = w * h * $urandom_range(1, 2) +
					(($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h - 1) : 0);
			// keep the random part near its item budget
			if (n > RANDOM_ITEMS - random_sent)
				n = RANDOM_ITEMS - random_sent;

			no_gaps    = (phase == 0) || ($urandom_range(0, 3) == 0);
			burst_left = $urandom_range(1, 16);
			for (i = 0; i < n; i++) begin
				if (phase == 0 && i == n / 2)
					wait_for_idle();
				if (burst_left == 0) begin
					if (!no_gaps)
						idle_gap($urandom_range(1, 6));
					burst_left = $urandom_range(1, 16);
				end
				send_pixel(PIX_W'($urandom), 1'b0, PIX_MIN);
				burst_left--;
			end
			random_sent += n;
			phase++;
		end

		// drain
		@(negedge clk);
		push <= 1'b0;
		waited = 0;
		while (pending_medians.size() != 0 && waited < END_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_medians.size() != 0)
			report_mismatch("results never delivered", 0, pending_medians.size());

		$display("Run covered %0d pixels over %0d geometry phases and %0d register writes,",
			pixels_taken, phase, reg_writes);
		$display("checking %0d results including %0d completed frames.",
			results_seen, frames_seen);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hard stop
	initial begin : watchdog
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("Run timed out with %0d results still expected", pending_medians.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
